// ----- rtl/spu_pkg.sv -----
// Package with the shared types and constants of the shower purge sequencer.
package spu_pkg;

  localparam int unsigned TempW = 7;

  localparam logic [TempW-1:0] PurgeTemp      = 7'd45;
  localparam logic [TempW-1:0] SetpointMax    = 7'd100;
  localparam logic [TempW-1:0] SetpointReset  = 7'd40;

  typedef enum logic [1:0] {
    CMD_NONE     = 2'd0,
    CMD_HANDHELD = 2'd1,
    CMD_RAIN     = 2'd2,
    CMD_STOP     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_RAIN     = 2'd0,
    MODE_HANDHELD = 2'd1,
    MODE_OFF      = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    PH_WAIT_START = 3'd0,
    PH_SET_OUTLET = 3'd1,
    PH_PURGE      = 3'd2,
    PH_WAIT_PURGE = 3'd3,
    PH_PREP_TEMP  = 3'd4,
    PH_WAIT_TEMP  = 3'd5,
    PH_LOOP       = 3'd6,
    PH_RESET      = 3'd7
  } phase_e;

  typedef struct packed {
    phase_e           phase;
    mode_e            req_mode;
    mode_e            app_mode;
    logic             gate;
    logic             outlet;
    logic             purge;
    logic [TempW-1:0] target;
  } seq_state_t;

  localparam seq_state_t StateReset = '{
    phase:    PH_WAIT_START,
    req_mode: MODE_OFF,
    app_mode: MODE_OFF,
    gate:     1'b0,
    outlet:   1'b0,
    purge:    1'b0,
    target:   '0
  };

endpackage

// ----- rtl/shower_purge_sequencer_unit.sv -----
// Top level of the shower purge sequencer with state and result registers.
// The unit takes one request per cycle while the result register is free and
// returns one result per request in the cycle after acceptance, holding the
// gate, outlet, purge valve, temperature target and phase after that request's
// step. The step is a single pass of next-state logic into the state
// registers, so a new request is accepted every cycle while the result register
// is empty or being taken in the same cycle. The user setpoint resets to 40
// degrees and is saturated to 100 when applied.
module shower_purge_sequencer_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [spu_pkg::TempW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                cmd_i,
  input  logic                      return_near_temp_i,
  input  logic                      source_at_temp_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      gate_open_o,
  output logic                      outlet_select_o,
  output logic                      purge_on_o,
  output logic [spu_pkg::TempW-1:0] temp_target_o,
  output logic [2:0]                phase_o
);
  import spu_pkg::*;

  seq_state_t       state_q, state_d;
  logic [TempW-1:0] setpoint_q;
  logic             out_valid_q;
  logic             gate_q, outlet_q, purge_q;
  logic [TempW-1:0] target_q;
  logic [2:0]       phase_q;
  logic             in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  spu_step u_step (
    .state_i            (state_q),
    .cmd_i              (cmd_i),
    .return_near_temp_i (return_near_temp_i),
    .source_at_temp_i   (source_at_temp_i),
    .setpoint_i         (setpoint_q),
    .state_o            (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      setpoint_q  <= SetpointReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        setpoint_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        state_q <= state_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      gate_q   <= state_d.gate;
      outlet_q <= state_d.outlet;
      purge_q  <= state_d.purge;
      target_q <= state_d.target;
      phase_q  <= state_d.phase;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign gate_open_o     = gate_q;
  assign outlet_select_o = outlet_q;
  assign purge_on_o      = purge_q;
  assign temp_target_o   = target_q;
  assign phase_o         = phase_q;

endmodule

// ----- rtl/spu_step.sv -----
// Next-state logic of the sequencer for one request.
module spu_step (
  input  spu_pkg::seq_state_t          state_i,
  input  logic [1:0]                   cmd_i,
  input  logic                         return_near_temp_i,
  input  logic                         source_at_temp_i,
  input  logic [spu_pkg::TempW-1:0]    setpoint_i,
  output spu_pkg::seq_state_t          state_o
);
  import spu_pkg::*;

  mode_e req_mode;

  always_comb begin
    case (cmd_e'(cmd_i))
      CMD_HANDHELD: req_mode = MODE_HANDHELD;
      CMD_RAIN:     req_mode = MODE_RAIN;
      CMD_STOP:     req_mode = MODE_OFF;
      default:      req_mode = state_i.req_mode;
    endcase
  end

  always_comb begin
    state_o          = state_i;
    state_o.req_mode = req_mode;
    case (state_i.phase)
      PH_WAIT_START: begin
        if (req_mode != MODE_OFF) begin
          state_o.phase    = PH_SET_OUTLET;
          state_o.app_mode = MODE_OFF;
        end
      end
      PH_SET_OUTLET: begin
        state_o.gate   = 1'b0;
        state_o.outlet = 1'b0;
        state_o.phase  = PH_PURGE;
      end
      PH_PURGE: begin
        state_o.purge  = 1'b1;
        state_o.target = PurgeTemp;
        state_o.gate   = 1'b1;
        state_o.phase  = PH_WAIT_PURGE;
      end
      PH_WAIT_PURGE: begin
        if (return_near_temp_i) begin
          state_o.phase = PH_PREP_TEMP;
        end
      end
      PH_PREP_TEMP: begin
        state_o.target = (setpoint_i > SetpointMax) ? SetpointMax : setpoint_i;
        state_o.phase  = PH_WAIT_TEMP;
      end
      PH_WAIT_TEMP: begin
        if (source_at_temp_i) begin
          state_o.purge = 1'b0;
          state_o.phase = PH_LOOP;
        end
      end
      PH_LOOP: begin
        if (state_i.app_mode != req_mode) begin
          if (req_mode == MODE_RAIN) begin
            state_o.outlet   = 1'b0;
            state_o.gate     = 1'b1;
            state_o.app_mode = MODE_RAIN;
          end else if (req_mode == MODE_HANDHELD) begin
            state_o.outlet   = 1'b1;
            state_o.gate     = 1'b1;
            state_o.app_mode = MODE_HANDHELD;
          end
        end
        if (req_mode == MODE_OFF) begin
          state_o.gate     = 1'b0;
          state_o.app_mode = MODE_OFF;
          state_o.phase    = PH_RESET;
        end
      end
      default: begin
        state_o.gate  = 1'b0;
        state_o.purge = 1'b0;
        state_o.phase = PH_WAIT_START;
      end
    endcase
  end

endmodule

// ----- test/tb_shower_purge_sequencer_unit.sv -----
// Self-checking testbench for the shower purge sequencer unit.
`timescale 1ns / 100ps

module tb_shower_purge_sequencer_unit;
  import spu_pkg::*;

  localparam int StallLimit   = 4000;
  localparam int ItemsPerRun  = 270;

  typedef struct packed {
    logic             gate;
    logic             outlet;
    logic             purge;
    logic [TempW-1:0] target;
    phase_e           phase;
  } tick_result_t;

  logic             clk_i;
  logic             rst_ni             = 1'b0;
  logic             cfg_we_i           = 1'b0;
  logic [TempW-1:0] cfg_wdata_i        = '0;
  logic             in_valid_i         = 1'b0;
  logic             in_ready_o;
  logic [1:0]       cmd_i              = CMD_NONE;
  logic             return_near_temp_i = 1'b0;
  logic             source_at_temp_i   = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i        = 1'b0;
  logic             gate_open_o;
  logic             outlet_select_o;
  logic             purge_on_o;
  logic [TempW-1:0] temp_target_o;
  logic [2:0]       phase_o;

  phase_e           seq_phase_q;
  mode_e            req_mode_q;
  mode_e            app_mode_q;
  logic             gate_q;
  logic             outlet_q;
  logic             purge_q;
  logic [TempW-1:0] target_q;
  logic [TempW-1:0] setpoint_q;

  tick_result_t     expected_ticks[$];
  int               error_count = 0;
  int               items_sent  = 0;
  int               stall_cycles = 0;
  bit               no_idle     = 1'b0;

  shower_purge_sequencer_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .cmd_i              (cmd_i),
    .return_near_temp_i (return_near_temp_i),
    .source_at_temp_i   (source_at_temp_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .gate_open_o        (gate_open_o),
    .outlet_select_o    (outlet_select_o),
    .purge_on_o         (purge_on_o),
    .temp_target_o      (temp_target_o),
    .phase_o            (phase_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic tick_result_t predict_tick(cmd_e cmd, logic ret_ok, logic src_ok);
    tick_result_t res;
    case (cmd)
      CMD_HANDHELD: req_mode_q = MODE_HANDHELD;
      CMD_RAIN:     req_mode_q = MODE_RAIN;
      CMD_STOP:     req_mode_q = MODE_OFF;
      default:      ;
    endcase
    case (seq_phase_q)
      PH_WAIT_START: begin
        if (req_mode_q != MODE_OFF) begin
          seq_phase_q = PH_SET_OUTLET;
          app_mode_q  = MODE_OFF;
        end
      end
      PH_SET_OUTLET: begin
        gate_q      = 1'b0;
        outlet_q    = 1'b0;
        seq_phase_q = PH_PURGE;
      end
      PH_PURGE: begin
        purge_q     = 1'b1;
        target_q    = PurgeTemp;
        gate_q      = 1'b1;
        seq_phase_q = PH_WAIT_PURGE;
      end
      PH_WAIT_PURGE: begin
        if (ret_ok) seq_phase_q = PH_PREP_TEMP;
      end
      PH_PREP_TEMP: begin
        target_q    = (setpoint_q > SetpointMax) ? SetpointMax : setpoint_q;
        seq_phase_q = PH_WAIT_TEMP;
      end
      PH_WAIT_TEMP: begin
        if (src_ok) begin
          purge_q     = 1'b0;
          seq_phase_q = PH_LOOP;
        end
      end
      PH_LOOP: begin
        if (app_mode_q != req_mode_q) begin
          if (req_mode_q == MODE_RAIN) begin
            outlet_q   = 1'b0;
            gate_q     = 1'b1;
            app_mode_q = MODE_RAIN;
          end else if (req_mode_q == MODE_HANDHELD) begin
            outlet_q   = 1'b1;
            gate_q     = 1'b1;
            app_mode_q = MODE_HANDHELD;
          end
        end
        if (req_mode_q == MODE_OFF) begin
          gate_q      = 1'b0;
          app_mode_q  = MODE_OFF;
          seq_phase_q = PH_RESET;
        end
      end
      default: begin
        gate_q      = 1'b0;
        purge_q     = 1'b0;
        seq_phase_q = PH_WAIT_START;
      end
    endcase
    res.gate   = gate_q;
    res.outlet = outlet_q;
    res.purge  = purge_q;
    res.target = target_q;
    res.phase  = seq_phase_q;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic send_tick(input cmd_e cmd, input logic ret_ok, input logic src_ok);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    cmd_i              <= cmd;
    return_near_temp_i <= ret_ok;
    source_at_temp_i   <= src_ok;
    do @(posedge clk_i); while (!in_ready_o);
    expected_ticks.push_back(predict_tick(cmd, ret_ok, src_ok));
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_setpoint(input logic [TempW-1:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    setpoint_q  = value;
  endtask

  task automatic test_start_and_modes();
    send_tick(CMD_NONE,     1'b1, 1'b1);
    send_tick(CMD_RAIN,     1'b0, 1'b0);
    send_tick(CMD_NONE,     1'b1, 1'b1);
    send_tick(CMD_NONE,     1'b0, 1'b0);
    send_tick(CMD_NONE,     1'b0, 1'b1);
    send_tick(CMD_NONE,     1'b1, 1'b0);
    send_tick(CMD_NONE,     1'b0, 1'b0);
    send_tick(CMD_NONE,     1'b1, 1'b0);
    send_tick(CMD_NONE,     1'b0, 1'b1);
    send_tick(CMD_NONE,     1'b0, 1'b0);
    send_tick(CMD_HANDHELD, 1'b0, 1'b0);
    send_tick(CMD_RAIN,     1'b1, 1'b1);
    send_tick(CMD_STOP,     1'b0, 1'b0);
    send_tick(CMD_NONE,     1'b0, 1'b0);
  endtask

  // A stop during the purge still runs the warm-up to the loop phase.
  task automatic test_stop_during_purge();
    write_setpoint(7'd127);
    send_tick(CMD_HANDHELD, 1'b0, 1'b0);
    send_tick(CMD_STOP,     1'b0, 1'b0);
    send_tick(CMD_NONE,     1'b0, 1'b0);
    send_tick(CMD_NONE,     1'b1, 1'b0);
    send_tick(CMD_NONE,     1'b0, 1'b0);
    send_tick(CMD_NONE,     1'b0, 1'b1);
    send_tick(CMD_NONE,     1'b0, 1'b0);
    send_tick(CMD_NONE,     1'b0, 1'b0);
  endtask

  task automatic run_session();
    int len;
    len = $urandom_range(4, 30);
    send_tick($urandom_range(1) ? CMD_RAIN : CMD_HANDHELD,
              1'($urandom_range(1)), 1'($urandom_range(1)));
    repeat (len) begin
      if ($urandom_range(99) < 85)
        send_tick(CMD_NONE, 1'($urandom_range(1)), 1'($urandom_range(1)));
      else
        send_tick(cmd_e'($urandom_range(1, 3)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
    end
    send_tick(CMD_STOP, 1'($urandom_range(1)), 1'($urandom_range(1)));
    repeat (2) send_tick(CMD_NONE, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic test_random_sessions(input logic [TempW-1:0] setpoint, input bit steady);
    int stop_at;
    write_setpoint(setpoint);
    no_idle = steady;
    stop_at = items_sent + ItemsPerRun;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 6))
          send_tick(cmd_e'($urandom_range(3)), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
      end else begin
        run_session();
      end
    end
    no_idle = 1'b0;
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(99) >= 33);
  end

  always @(posedge clk_i) begin
    tick_result_t exp_tick;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_ticks.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        exp_tick = expected_ticks.pop_front();
        if (gate_open_o !== exp_tick.gate)
          report_mismatch($sformatf("gate_open %0b, expected %0b", gate_open_o, exp_tick.gate));
        if (outlet_select_o !== exp_tick.outlet)
          report_mismatch($sformatf("outlet_select %0b, expected %0b",
                                    outlet_select_o, exp_tick.outlet));
        if (purge_on_o !== exp_tick.purge)
          report_mismatch($sformatf("purge_on %0b, expected %0b", purge_on_o, exp_tick.purge));
        if (temp_target_o !== exp_tick.target)
          report_mismatch($sformatf("temp_target %0d, expected %0d",
                                    temp_target_o, exp_tick.target));
        if (phase_o !== exp_tick.phase)
          report_mismatch($sformatf("phase %0d, expected %0d", phase_o, exp_tick.phase));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("tb_shower_purge_sequencer_unit failed");
          $finish;
        end
      end
    end
  end

  initial begin
    seq_phase_q = PH_WAIT_START;
    req_mode_q  = MODE_OFF;
    app_mode_q  = MODE_OFF;
    gate_q      = 1'b0;
    outlet_q    = 1'b0;
    purge_q     = 1'b0;
    target_q    = '0;
    setpoint_q  = SetpointReset;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_start_and_modes();
    test_stop_during_purge();
    test_random_sessions(7'd0, 1'b0);
    test_random_sessions(7'd100, 1'b0);
    test_random_sessions(7'd127, 1'b1);
    test_random_sessions(7'($urandom_range(127)), 1'b0);
    test_random_sessions(7'($urandom_range(127)), 1'b0);

    wait_drained();
    repeat (5) @(posedge clk_i);
    if (expected_ticks.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_ticks.size()));
    if (error_count == 0) begin
      $display("tb_shower_purge_sequencer_unit passed");
    end else begin
      $display("tb_shower_purge_sequencer_unit failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/spu_pkg.sv
rtl/spu_step.sv
rtl/shower_purge_sequencer_unit.sv
test/tb_shower_purge_sequencer_unit.sv
